### rtl/core/compacting_element_list_top_assert.svh
// ----------------------------------------------------------------------------
// compacting_element_list_top_assert
// Assertion macros shared by the compacting element list RTL.
// Each macro checks an implication on the rising edge of clk and is
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef COMPACTING_ELEMENT_LIST_TOP_ASSERT_SVH
`define COMPACTING_ELEMENT_LIST_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define CEL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("compacting element list check failed");
// Next-cycle implication.
`define CEL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("compacting element list check failed");
`else
`define CEL_ASSERT_NOW(label, ante, cons)
`define CEL_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/core/cel_pkg.sv
// ----------------------------------------------------------------------------
// cel_pkg
// Constants, codes and types shared by the compacting element list modules.
// ----------------------------------------------------------------------------
package cel_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 64;
    localparam int POS_W    = 7;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam int GRP_SIZE = 8;
    localparam int NGROUP   = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

    localparam logic [2:0] OP_APPEND = 3'd0;
    localparam logic [2:0] OP_READ   = 3'd1;
    localparam logic [2:0] OP_WRITE  = 3'd2;
    localparam logic [2:0] OP_REMOVE = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        logic              load;
        logic              shift;
        logic              zero;
        logic [IDX_W-1:0]  slot;
        logic [DATA_W-1:0] value;
    } cel_cmd_t;

endpackage

### rtl/core/cel_cell.sv
// ----------------------------------------------------------------------------
// cel_cell
// One storage slot of the list: loads, clears, or takes its upper neighbor's
// element during a remove, and offers its element when it is the selected slot.
// ----------------------------------------------------------------------------
module cel_cell (
    input  logic                        clk,
    input  logic [cel_pkg::IDX_W-1:0]   idx,
    input  cel_pkg::cel_cmd_t           cmd,
    input  logic [cel_pkg::DATA_W-1:0]  up_data,
    output logic [cel_pkg::DATA_W-1:0]  data,
    output logic [cel_pkg::DATA_W-1:0]  sel_data
);

    logic [cel_pkg::DATA_W-1:0] data_reg;
    logic [cel_pkg::DATA_W-1:0] data_next;
    logic                       sel;

    assign sel = (idx == cmd.slot);

    always_comb
    begin
        data_next = data_reg;
        if (cmd.zero)
        begin
            data_next = '0;
        end
        else if (cmd.load && sel)
        begin
            data_next = cmd.value;
        end
        else if (cmd.shift && (idx >= cmd.slot))
        begin
            data_next = up_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    assign sel_data = sel ? data_reg : '0;

endmodule

### rtl/core/cel_chain.sv
// ----------------------------------------------------------------------------
// cel_chain
// The row of cells, each linked to its upper neighbor, and the first level of
// the registered OR tree that collects the selected slot's element.
// ----------------------------------------------------------------------------
module cel_chain (
    input  logic                                             clk,
    input  cel_pkg::cel_cmd_t                                cmd,
    output logic [cel_pkg::NGROUP-1:0][cel_pkg::DATA_W-1:0]  grp
);

    logic [cel_pkg::CAPACITY-1:0][cel_pkg::DATA_W-1:0] cell_data;
    logic [cel_pkg::CAPACITY-1:0][cel_pkg::DATA_W-1:0] cell_sel;
    logic [cel_pkg::NGROUP-1:0][cel_pkg::DATA_W-1:0]   grp_reg;
    logic [cel_pkg::NGROUP-1:0][cel_pkg::DATA_W-1:0]   grp_next;

    for (genvar i = 0; i < cel_pkg::CAPACITY; i++)
    begin : g_cell
        logic [cel_pkg::DATA_W-1:0] up_data;
        if (i == cel_pkg::CAPACITY - 1)
        begin : g_top
            // The top cell has no neighbor and keeps its value on a remove.
            assign up_data = cell_data[i];
        end
        else
        begin : g_mid
            assign up_data = cell_data[i+1];
        end
        cel_cell u_cell (
            .clk      (clk),
            .idx      (cel_pkg::IDX_W'(i)),
            .cmd      (cmd),
            .up_data  (up_data),
            .data     (cell_data[i]),
            .sel_data (cell_sel[i])
        );
    end

    always_comb
    begin
        for (int g = 0; g < cel_pkg::NGROUP; g++)
        begin
            grp_next[g] = '0;
            for (int k = 0; k < cel_pkg::GRP_SIZE; k++)
            begin
                if (g * cel_pkg::GRP_SIZE + k < cel_pkg::CAPACITY)
                begin
                    grp_next[g] = grp_next[g] | cell_sel[g * cel_pkg::GRP_SIZE + k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg <= grp_next;
    end

    assign grp = grp_reg;

endmodule

### rtl/core/compacting_element_list_top.sv
// ----------------------------------------------------------------------------
// compacting_element_list_top
// Fixed-capacity ordered list of 64-bit elements with append, read, write,
// remove and clear, built as a row of storage cells.
// ----------------------------------------------------------------------------
// Usage:
// An operation is transferred at a rising edge where start is high and busy
// is low; op, position and data_in are sampled at that edge.
// The block then steps through EXEC, which decodes the position and acts
// on the cell row (a remove moves every later element down during EXEC),
// COLLECT, which folds the selected element through the second level of
// the OR tree, and a final cycle in which the result is shown.
// The result is on data_out, status, count_now and empty_flag for exactly
// one cycle while done is high; busy is already low in that cycle, so the
// next operation may be transferred there; a new operation is taken only
// once the previous one has finished.
// The receiver cannot stall: a result must be taken in its done cycle.
// Reset empties the list (count zero) and leaves the block idle; element
// slots at or above the count are never read, so they are not cleared.
// ----------------------------------------------------------------------------
`include "compacting_element_list_top_assert.svh"

module compacting_element_list_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [2:0]                   op,
    input  logic signed [6:0]            position,
    input  logic [cel_pkg::DATA_W-1:0]   data_in,
    output logic                         done,
    output logic [cel_pkg::DATA_W-1:0]   data_out,
    output logic [1:0]                   status,
    output logic [6:0]                   count_now,
    output logic                         empty_flag
);

    typedef enum logic [1:0] {
        IDLE,
        EXEC,
        COLLECT
    } state_t;

    state_t                            state_reg;
    logic [2:0]                        op_reg;
    logic [cel_pkg::POS_W-1:0]         pos_reg;
    logic [cel_pkg::DATA_W-1:0]        din_reg;
    logic [cel_pkg::CNT_W-1:0]         count_reg;
    logic [cel_pkg::CNT_W-1:0]         count_next;
    logic [1:0]                        st_reg;
    logic [1:0]                        st_next;
    logic                              ret_reg;
    logic                              ret_next;
    logic                              done_reg;
    logic [cel_pkg::DATA_W-1:0]        data_out_reg;
    logic [1:0]                        status_reg;
    logic [6:0]                        count_now_reg;
    logic                              empty_reg;

    logic [cel_pkg::CMP_W-1:0]         cnt_w;
    logic [cel_pkg::CMP_W-1:0]         pos_w;
    logic [cel_pkg::CMP_W-1:0]         back_w;
    logic [cel_pkg::CMP_W-1:0]         slot_w;
    logic                              neg;
    logic                              pos_ok;
    logic                              full;
    logic                              is_access;
    cel_pkg::cel_cmd_t                 cmd;
    logic [cel_pkg::NGROUP-1:0][cel_pkg::DATA_W-1:0] grp;
    logic [cel_pkg::DATA_W-1:0]        grp_or;

    // Position resolution: a negative position counts back from the count.
    assign neg    = pos_reg[cel_pkg::POS_W-1];
    assign cnt_w  = cel_pkg::CMP_W'(count_reg);
    assign pos_w  = cel_pkg::CMP_W'(pos_reg);
    assign back_w = cel_pkg::CMP_W'(cel_pkg::POS_W'(~pos_reg + 1'b1));
    assign pos_ok = neg ? (back_w <= cnt_w) : (pos_w < cnt_w);
    assign slot_w = neg ? (cnt_w - back_w) : pos_w;
    assign full   = (count_reg == cel_pkg::CNT_W'(cel_pkg::CAPACITY));
    assign is_access = (op_reg == cel_pkg::OP_READ) || (op_reg == cel_pkg::OP_WRITE)
                       || (op_reg == cel_pkg::OP_REMOVE);

    always_comb
    begin
        cmd        = '0;
        cmd.value  = din_reg;
        cmd.slot   = slot_w[cel_pkg::IDX_W-1:0];
        count_next = count_reg;
        st_next    = cel_pkg::ST_OK;
        ret_next   = 1'b0;
        if (state_reg == EXEC)
        begin
            if (op_reg == cel_pkg::OP_APPEND)
            begin
                if (full)
                begin
                    st_next = cel_pkg::ST_FULL;
                end
                else
                begin
                    cmd.load   = 1'b1;
                    cmd.slot   = count_reg[cel_pkg::IDX_W-1:0];
                    count_next = count_reg + cel_pkg::CNT_W'(1);
                end
            end
            else if (is_access)
            begin
                if (count_reg == '0)
                begin
                    st_next = cel_pkg::ST_EMPTY;
                end
                else if (!pos_ok)
                begin
                    st_next = cel_pkg::ST_RANGE;
                end
                else
                begin
                    case (op_reg)
                        cel_pkg::OP_READ:
                        begin
                            ret_next = 1'b1;
                        end
                        cel_pkg::OP_WRITE:
                        begin
                            cmd.load = 1'b1;
                        end
                        cel_pkg::OP_REMOVE:
                        begin
                            ret_next   = 1'b1;
                            cmd.shift  = 1'b1;
                            count_next = count_reg - cel_pkg::CNT_W'(1);
                        end
                        default:
                        begin
                            ret_next = 1'b0;
                        end
                    endcase
                end
            end
            else if (op_reg == cel_pkg::OP_CLEAR)
            begin
                cmd.zero   = 1'b1;
                count_next = '0;
            end
        end
    end

    cel_chain u_chain (
        .clk (clk),
        .cmd (cmd),
        .grp (grp)
    );

    always_comb
    begin
        grp_or = '0;
        for (int g = 0; g < cel_pkg::NGROUP; g++)
        begin
            grp_or = grp_or | grp[g];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= EXEC;
                    end
                end
                EXEC:
                begin
                    count_reg <= count_next;
                    state_reg <= COLLECT;
                end
                COLLECT:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= IDLE;
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    // Operation and result payload.
    always_ff @(posedge clk)
    begin
        if ((state_reg == IDLE) && start)
        begin
            op_reg  <= op;
            pos_reg <= position;
            din_reg <= data_in;
        end
        if (state_reg == EXEC)
        begin
            st_reg  <= st_next;
            ret_reg <= ret_next;
        end
        if (state_reg == COLLECT)
        begin
            data_out_reg  <= ret_reg ? grp_or : '0;
            status_reg    <= st_reg;
            count_now_reg <= 7'(count_reg);
            empty_reg     <= (count_reg == '0);
        end
    end

    assign busy       = (state_reg != IDLE);
    assign done       = done_reg;
    assign data_out   = data_out_reg;
    assign status     = status_reg;
    assign count_now  = count_now_reg;
    assign empty_flag = empty_reg;

    `CEL_ASSERT_NEXT(a_start_enters_exec, start && !busy, state_reg == EXEC)
    `CEL_ASSERT_NEXT(a_collect_gives_done, state_reg == COLLECT, done)
    `CEL_ASSERT_NOW(a_count_bounded, 1'b1, count_reg <= cel_pkg::CNT_W'(cel_pkg::CAPACITY))
    `CEL_ASSERT_NOW(a_empty_tracks_count, done, empty_flag == (count_reg == '0))
    `CEL_ASSERT_NEXT(a_full_append_holds, (state_reg == EXEC) && (op_reg == cel_pkg::OP_APPEND) && full, count_reg == $past(count_reg))

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the compacting element list. An initial block
// builds a backlog of list operations: a short directed sweep, then random
// fill, drain, clear and mixed bursts. A clocked driver issues them with random
// gaps, and a clocked monitor runs its own list model on every accepted
// transfer and checks each done result against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import cel_pkg::*;

    localparam logic [2:0] OP_SPARE_LO  = 3'd5;
    localparam logic [2:0] OP_SPARE_MID = 3'd6;
    localparam logic [2:0] OP_SPARE_HI  = 3'd7;
    localparam int         ITEM_TARGET  = 450;

    typedef struct {
        logic [2:0]        code;
        logic signed [6:0] pos;
        logic [63:0]       value;
        int unsigned       gap;
    } list_cmd_t;

    typedef struct {
        logic [63:0] data;
        logic [1:0]  status;
        logic [6:0]  count;
        logic        empty;
    } list_result_t;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              start      = 1'b0;
    logic [2:0]        op         = OP_READ;
    logic signed [6:0] position   = '0;
    logic [63:0]       data_in    = '0;
    logic              busy;
    logic              done;
    logic [63:0]       data_out;
    logic [1:0]        status;
    logic [6:0]        count_now;
    logic              empty_flag;

    list_cmd_t    op_backlog[$];
    list_result_t predicted_results[$];
    logic [63:0]  list_mem[CAPACITY];
    int           list_len = 0;
    int           error_count = 0;
    int unsigned  gap_left = 0;
    logic         launched = 1'b0;

    // Stimulus-side bookkeeping: the length the list will have once every
    // queued operation has run, used to aim positions at live entries.
    int           plan_len = 0;
    bit           calm = 1'b1;

    compacting_element_list_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .op         (op),
        .position   (position),
        .data_in    (data_in),
        .done       (done),
        .data_out   (data_out),
        .status     (status),
        .count_now  (count_now),
        .empty_flag (empty_flag)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // List model
    // ------------------------------------------------------------------
    function automatic list_result_t apply_list_op(logic [2:0] code, logic signed [6:0] pos,
                                                   logic [63:0] value);
        list_result_t r;
        int p;
        int slot;
        int i;
        r.data   = '0;
        r.status = ST_OK;
        p        = pos;
        case (code)
            OP_APPEND:
            begin
                if (list_len >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    list_mem[list_len] = value;
                    list_len++;
                end
            end
            OP_READ, OP_WRITE, OP_REMOVE:
            begin
                // The empty check wins over the position check.
                if (list_len == 0)
                    r.status = ST_EMPTY;
                else if (p >= list_len || -p > list_len)
                    r.status = ST_RANGE;
                else
                begin
                    slot = (p < 0) ? list_len + p : p;
                    if (code == OP_READ)
                        r.data = list_mem[slot];
                    else if (code == OP_WRITE)
                        list_mem[slot] = value;
                    else
                    begin
                        r.data = list_mem[slot];
                        for (i = slot; i < list_len - 1; i++)
                            list_mem[i] = list_mem[i + 1];
                        list_len--;
                    end
                end
            end
            OP_CLEAR:
            begin
                foreach (list_mem[k])
                    list_mem[k] = '0;
                list_len = 0;
            end
            default:
            begin
            end
        endcase
        r.count = 7'(list_len);
        r.empty = (list_len == 0);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic bit pos_hits(logic signed [6:0] pos, int len);
        int p;
        p = pos;
        return (len > 0) && (p < len) && (-p <= len);
    endfunction

    function automatic logic [63:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic int unsigned pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // A live position, written from the front or from the back at random.
    function automatic logic signed [6:0] pick_live_pos();
        int slot;
        slot = $urandom_range(0, plan_len - 1);
        if ($urandom_range(0, 1))
            return 7'(slot);
        return 7'(slot - plan_len);
    endfunction

    task automatic queue_op(logic [2:0] code, logic signed [6:0] pos, logic [63:0] value);
        list_cmd_t c;
        c.code  = code;
        c.pos   = pos;
        c.value = value;
        c.gap   = pick_gap();
        op_backlog.push_back(c);
        if (code == OP_APPEND && plan_len < CAPACITY)
            plan_len++;
        else if (code == OP_REMOVE && pos_hits(pos, plan_len))
            plan_len--;
        else if (code == OP_CLEAR)
            plan_len = 0;
    endtask

    task automatic queue_fill();
        int extra;
        extra = $urandom_range(1, 3);
        while (plan_len < CAPACITY)
            queue_op(OP_APPEND, 7'($urandom), pick_word());
        repeat (extra)
            queue_op(OP_APPEND, 7'($urandom), pick_word());
        // Both extreme positions are live only when the list is full.
        queue_op(OP_READ, 7'sd63, pick_word());
        queue_op(OP_READ, -7'sd64, pick_word());
        queue_op(OP_WRITE, -7'sd64, pick_word());
        queue_op(OP_REMOVE, -7'sd64, pick_word());
    endtask

    task automatic queue_drain();
        while (plan_len > 0)
            queue_op(OP_REMOVE, pick_live_pos(), pick_word());
        queue_op(OP_REMOVE, 7'($urandom), pick_word());
    endtask

    task automatic queue_mixed();
        int n;
        int r;
        logic [2:0] code;
        logic signed [6:0] pos;
        n = $urandom_range(8, 20);
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
                code = OP_APPEND;
            else if (r < 55)
                code = OP_READ;
            else if (r < 72)
                code = OP_WRITE;
            else if (r < 94)
                code = OP_REMOVE;
            else if (r < 96)
                code = OP_CLEAR;
            else
                code = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            if (plan_len > 0 && $urandom_range(0, 99) < 85)
                pos = pick_live_pos();
            else
                pos = 7'($urandom);
            queue_op(code, pos, pick_word());
        end
    endtask

    // ------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        list_cmd_t next_cmd;
        // Hold the current operation until its transfer has happened.
        if (rst_n && !(start && !launched))
        begin
            if (gap_left != 0)
            begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (op_backlog.size() != 0)
            begin
                next_cmd = op_backlog.pop_front();
                op       <= next_cmd.code;
                position <= next_cmd.pos;
                data_in  <= next_cmd.value;
                start    <= 1'b1;
                gap_left <= next_cmd.gap;
            end
            else
                start <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor and checker
    // ------------------------------------------------------------------
    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n)
        begin
            // A result leaves before a new transfer is modeled in the same cycle.
            if (done)
            begin
                if (predicted_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got data %h status %0d",
                             $time, data_out, status);
                    error_count++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    check_field("data_out", want.data, data_out);
                    check_field("status", 64'(want.status), 64'(status));
                    check_field("count_now", 64'(want.count), 64'(count_now));
                    check_field("empty_flag", 64'(want.empty), 64'(empty_flag));
                end
            end
            if (start && !busy)
                predicted_results.push_back(apply_list_op(op, position, data_in));
            launched <= start && !busy;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        int first_random;
        int kind;

        foreach (list_mem[k])
            list_mem[k] = '0;

        // Directed sweep: accesses on an empty list, spare codes, extreme
        // values, both ends of the position range and just past them.
        calm = 1'b1;
        queue_op(OP_READ, 7'sd0, '0);
        queue_op(OP_WRITE, -7'sd1, '1);
        queue_op(OP_REMOVE, 7'sd63, '0);
        queue_op(OP_SPARE_LO, -7'sd64, '1);
        queue_op(OP_SPARE_MID, 7'sd21, pick_word());
        queue_op(OP_SPARE_HI, -7'sd22, pick_word());
        queue_op(OP_APPEND, 7'sd0, '0);
        queue_op(OP_APPEND, -7'sd1, '1);
        queue_op(OP_APPEND, 7'sd0, {16{4'hA}});
        queue_op(OP_APPEND, 7'sd0, {16{4'h5}});
        calm = 1'b0;
        queue_op(OP_READ, 7'sd0, '0);
        queue_op(OP_READ, -7'sd1, '0);
        queue_op(OP_READ, 7'sd4, '0);
        queue_op(OP_READ, -7'sd5, '0);
        queue_op(OP_READ, -7'sd4, '0);
        queue_op(OP_WRITE, -7'sd1, 64'h0123_4567_89AB_CDEF);
        queue_op(OP_READ, 7'sd3, '0);
        queue_op(OP_REMOVE, 7'sd1, '0);
        queue_op(OP_REMOVE, -7'sd1, '0);
        queue_op(OP_READ, 7'sd63, '0);
        queue_op(OP_READ, -7'sd64, '0);
        queue_op(OP_CLEAR, 7'sd5, '1);
        queue_op(OP_READ, 7'sd0, '0);
        queue_op(OP_APPEND, 7'sd0, pick_word());
        queue_op(OP_SPARE_HI, 7'sd0, pick_word());

        // Random bursts; one fill to capacity is always included.
        first_random = op_backlog.size();
        queue_fill();
        while (op_backlog.size() - first_random < ITEM_TARGET)
        begin
            calm = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 9);
            if (kind == 0)
                queue_fill();
            else if (kind == 1)
                queue_drain();
            else if (kind == 2)
                queue_op(OP_CLEAR, 7'($urandom), pick_word());
            else
                queue_mixed();
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (op_backlog.size() != 0 || start || predicted_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/cel_pkg.sv
rtl/core/cel_cell.sv
rtl/core/cel_chain.sv
rtl/core/compacting_element_list_top.sv
tb/tb_top.sv
